// ----- sv/sssp_pkg.sv -----
// sssp_pkg: constants and controller/datapath command and status types for the
// shortest-path block. No dependencies.
`timescale 1ns / 1ps
package sssp_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges = 256;
	localparam int WeightBits = 16;
	localparam int VertBits = $clog2(MaxVertices);
	localparam int EdgeBits = $clog2(MaxEdges);
	localparam int DistBits = 31;
	localparam logic [DistBits-1:0] DistInf = {DistBits{1'b1}};
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	typedef struct packed {
		logic init_clr;   // write infinity/unsettled at scan index
		logic set_src;    // write zero at source
		logic scan_clr;   // clear min-search accumulators
		logic scan_step;  // compare one vertex into minimum
		logic settle;     // mark pick settled
		logic edge_step;  // relax one edge
		logic out_step;   // emit one result
		logic idx_clr;    // reset vertex/edge index
		logic [VertBits-1:0] src;
	} sssp_cmd_t;

	typedef struct packed {
		logic vidx_last;  // vertex index is at n-1
		logic eidx_last;  // edge index is at last stored edge
		logic no_edges;
		logic found;      // minimum search found a vertex
		logic relax_busy; // edge read stage of relax still holds an edge
	} sssp_sts_t;
endpackage

// ----- sv/sssp_datapath.sv -----
// sssp_datapath: edge store, distance and settled memories, min search and relax.
// Depends on sssp_pkg.
`timescale 1ns / 1ps
module sssp_datapath (
	input  logic clk,
	input  logic arst_n,
	input  sssp_pkg::sssp_cmd_t cmd,
	output sssp_pkg::sssp_sts_t sts,
	input  logic add_en,
	input  logic [sssp_pkg::VertBits-1:0] node_a,
	input  logic [sssp_pkg::VertBits-1:0] node_b,
	input  logic [15:0] edge_weight,
	input  logic [sssp_pkg::VertBits:0] n_act,
	output logic [sssp_pkg::VertBits-1:0] vertex_index,
	output logic [sssp_pkg::DistBits-1:0] distance,
	output logic edges_dropped
);
	import sssp_pkg::*;
	localparam int EW = 2*VertBits + WeightBits;

	logic [EW-1:0] edge_mem [MaxEdges];
	logic [DistBits-1:0] dist_q [MaxVertices];
	logic [MaxVertices-1:0] settled_q;
	logic [EdgeBits:0] edge_total_q;
	logic drop_q;
	logic [VertBits-1:0] vidx_q;
	logic [EdgeBits-1:0] eidx_q;
	logic [VertBits-1:0] pick_q;
	logic [DistBits-1:0] low_q, pick_dist_q;
	logic found_q;
	logic [EW-1:0] edge_rd_q;
	logic rd_valid_q;

	logic ok;
	assign ok = ({1'b0, node_a} < n_act) && ({1'b0, node_b} < n_act)
		&& (edge_total_q != (EdgeBits+1)'(MaxEdges));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			drop_q <= 1'b0;
		end else if (add_en) begin
			if (ok) edge_total_q <= edge_total_q + 1'b1;
			else drop_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (add_en && ok)
			edge_mem[edge_total_q[EdgeBits-1:0]] <= {node_a, node_b, edge_weight[WeightBits-1:0]};
		edge_rd_q <= edge_mem[eidx_q];
	end

	// min scan: vertex read registered, compared in the following cycle
	logic scan_v_s1, scan_set_s1;
	logic [DistBits-1:0] scan_d_s1;
	logic [VertBits-1:0] scan_i_s1;
	logic take;
	logic [DistBits-1:0] low_nx;
	logic [VertBits-1:0] pick_nx;
	logic found_nx;
	always_comb begin
		take = scan_v_s1 && !scan_set_s1 && (scan_d_s1 < low_q);
		low_nx = take ? scan_d_s1 : low_q;
		pick_nx = take ? scan_i_s1 : pick_q;
		found_nx = found_q || take;
	end

	// edge relax: edge read registered ahead of the compare; rd_valid marks pipelined read
	logic [VertBits-1:0] ea, eb, other;
	logic [WeightBits-1:0] ew;
	logic hit;
	logic [DistBits:0] sum;
	logic [DistBits-1:0] nd;
	always_comb begin
		{ea, eb, ew} = edge_rd_q;
		hit = rd_valid_q && ({1'b0, ea} < n_act) && ({1'b0, eb} < n_act)
			&& (ea == pick_q || eb == pick_q);
		other = (ea == pick_q) ? eb : ea;
		sum = {1'b0, pick_dist_q} + (DistBits+1)'(ew);
		nd = sum[DistBits] ? DistInf : sum[DistBits-1:0];
	end

	// second relax stage; the write of the previous beat is forwarded
	logic hit_s1;
	logic [VertBits-1:0] other_s1;
	logic [DistBits-1:0] nd_s1, old_s1;
	logic wr_q;
	logic [VertBits-1:0] wr_addr_q;
	logic [DistBits-1:0] wr_data_q;
	logic [DistBits-1:0] cur;
	logic rlx_wr;
	always_comb begin
		cur = (wr_q && wr_addr_q == other_s1) ? wr_data_q : old_s1;
		rlx_wr = hit_s1 && (nd_s1 < cur);
	end

	always_ff @(posedge clk) begin
		if (cmd.init_clr) dist_q[vidx_q] <= DistInf;
		else if (cmd.set_src) dist_q[cmd.src] <= '0;
		else if (rlx_wr) dist_q[other_s1] <= nd_s1;
		if (cmd.init_clr) settled_q[vidx_q] <= 1'b0;
		else if (cmd.settle) settled_q[pick_nx] <= 1'b1;
		if (cmd.scan_clr) begin
			low_q <= DistInf;
			found_q <= 1'b0;
		end else begin
			low_q <= low_nx;
			pick_q <= pick_nx;
			found_q <= found_nx;
		end
		if (cmd.settle) pick_dist_q <= low_nx;
		scan_d_s1 <= dist_q[vidx_q];
		scan_set_s1 <= settled_q[vidx_q];
		scan_i_s1 <= vidx_q;
		other_s1 <= other;
		nd_s1 <= nd;
		old_s1 <= dist_q[other];
		wr_addr_q <= other_s1;
		wr_data_q <= nd_s1;
		vertex_index <= vidx_q;
		distance <= dist_q[vidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q <= '0;
			eidx_q <= '0;
			rd_valid_q <= 1'b0;
			hit_s1 <= 1'b0;
			scan_v_s1 <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			rd_valid_q <= cmd.edge_step;
			hit_s1 <= hit;
			scan_v_s1 <= cmd.scan_step;
			wr_q <= rlx_wr;
			if (cmd.idx_clr) begin
				vidx_q <= '0;
				eidx_q <= '0;
			end else begin
				if (cmd.init_clr || cmd.scan_step || cmd.out_step) vidx_q <= vidx_q + 1'b1;
				if (cmd.edge_step) eidx_q <= eidx_q + 1'b1;
			end
		end
	end

	assign edges_dropped = drop_q;
	assign sts.vidx_last = ({1'b0, vidx_q} == n_act - 1'b1);
	assign sts.eidx_last = ({1'b0, eidx_q} == edge_total_q - 1'b1);
	assign sts.no_edges = (edge_total_q == '0);
	assign sts.found = found_nx;
	assign sts.relax_busy = rd_valid_q;
endmodule

// ----- sv/sssp_ctrl.sv -----
// sssp_ctrl: run sequencer (init, min scan, settle, relax sweep, emit).
// Depends on sssp_pkg.
`timescale 1ns / 1ps
module sssp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic run_go,
	input  logic [sssp_pkg::VertBits-1:0] src,
	input  logic src_ok,
	input  sssp_pkg::sssp_sts_t sts,
	output sssp_pkg::sssp_cmd_t cmd,
	output logic busy,
	output logic done,
	output logic last
);
	import sssp_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_SCAN = 3'd2, S_PICK = 3'd3,
		S_EDGE = 3'd4, S_DRAIN = 3'd5, S_OUT = 3'd6, S_SRC = 3'd7;
	logic [2:0] state_q;
	logic [VertBits-1:0] src_q;
	logic src_ok_q, out_v_q, out_l_q;

	always_comb begin
		cmd = '0;
		cmd.src = src_q;
		case (state_q)
			S_INIT: cmd.init_clr = 1'b1;
			S_SCAN: cmd.scan_step = 1'b1;
			S_PICK: cmd.settle = sts.found;
			S_EDGE: cmd.edge_step = 1'b1;
			S_OUT: cmd.out_step = 1'b1;
			S_SRC: cmd.set_src = src_ok_q;
			default: ;
		endcase
		if (state_q == S_SRC || state_q == S_DRAIN) cmd.scan_clr = 1'b1;
		if ((state_q == S_INIT && sts.vidx_last) || state_q == S_SRC
			|| (state_q == S_SCAN && sts.vidx_last) || (state_q == S_PICK)
			|| state_q == S_DRAIN || run_go)
			cmd.idx_clr = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			out_l_q <= 1'b0;
			src_ok_q <= 1'b0;
			src_q <= '0;
		end else begin
			out_v_q <= state_q == S_OUT;
			out_l_q <= state_q == S_OUT && sts.vidx_last;
			case (state_q)
				S_IDLE: if (run_go) begin
					src_q <= src;
					src_ok_q <= src_ok;
					state_q <= S_INIT;
				end
				S_INIT: if (sts.vidx_last) state_q <= S_SRC;
				S_SRC: state_q <= src_ok_q ? S_SCAN : S_OUT;
				S_SCAN: if (sts.vidx_last) state_q <= S_PICK;
				S_PICK: state_q <= !sts.found ? S_OUT : (sts.no_edges ? S_DRAIN : S_EDGE);
				S_EDGE: if (sts.eidx_last) state_q <= S_DRAIN;
				// hold until the last edge has left the edge read stage of the relax pipeline
				S_DRAIN: if (!sts.relax_busy) state_q <= S_SCAN;
				S_OUT: if (sts.vidx_last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE || out_v_q;
	assign done = out_v_q;
	assign last = out_l_q;
endmodule

// ----- sv/single_source_shortest_paths_top.sv -----
// Shortest-path block: a run's length is set by the per-settle vertex scan
// and edge-store sweep through one read port; start is ignored while busy.
// Results come one per cycle, n beats; receiver cannot stall.
// Reset clears edge count, drop flag, controller; vertex_count resets to 64.
`timescale 1ns / 1ps
module single_source_shortest_paths_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic opcode,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	input  logic [15:0] edge_weight,
	output logic done,
	output logic [5:0] vertex_index,
	output logic [30:0] distance,
	output logic last_vertex,
	output logic edges_dropped
);
	import sssp_pkg::*;
	logic [6:0] vcount_q;
	logic [VertBits:0] n_act;
	sssp_cmd_t cmd;
	sssp_sts_t sts;
	logic acc, add_en, run_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= 7'(MaxVertices);
		else if (cfg_we) vcount_q <= cfg_wdata;
	end
	assign n_act = (vcount_q == '0) ? (VertBits+1)'(1)
		: (vcount_q > 7'(MaxVertices)) ? (VertBits+1)'(MaxVertices) : vcount_q[VertBits:0];

	assign acc = start && !busy;
	assign add_en = acc && opcode == OP_ADD;
	assign run_go = acc && opcode == OP_RUN;

	sssp_ctrl u_ctrl (.clk, .arst_n, .run_go, .src(node_a),
		.src_ok({1'b0, node_a} < n_act), .sts, .cmd, .busy, .done, .last(last_vertex));
	sssp_datapath u_dp (.clk, .arst_n, .cmd, .sts, .add_en, .node_a, .node_b, .edge_weight,
		.n_act, .vertex_index, .distance, .edges_dropped);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_vertex) |=> !done) else $error("beat after last");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_vertex) |-> ({1'b0, vertex_index} == n_act - 1'b1))
		else $error("last flag on wrong vertex");
endmodule

// ----- dv/sssp_checker.sv -----
// sssp_checker: watches the command, configuration and result ports of the
// shortest-path block, predicts every result beat and compares them.
// Depends on sssp_pkg.
`timescale 1ns / 1ps
module sssp_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic opcode,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	input  logic [15:0] edge_weight,
	input  logic done,
	input  logic [5:0] vertex_index,
	input  logic [30:0] distance,
	input  logic last_vertex,
	input  logic edges_dropped,
	output int errors,
	output int pending,
	output int checked,
	output int runs_seen
);
	import sssp_pkg::*;

	typedef struct {
		logic [VertBits-1:0] vidx;
		logic [DistBits-1:0] path_dist;
		logic last;
		logic dropped;
	} dist_beat_t;

	logic [VertBits-1:0] store_a[MaxEdges];
	logic [VertBits-1:0] store_b[MaxEdges];
	logic [WeightBits-1:0] store_w[MaxEdges];
	int stored_edges;
	logic drop_seen;
	logic [6:0] vcount;
	logic [DistBits-1:0] path_len[MaxVertices];
	dist_beat_t expected_dists[$];

	function automatic int live_vertices();
		if (vcount == 0) return 1;
		if (vcount > MaxVertices) return MaxVertices;
		return vcount;
	endfunction

	// Settles the least unsettled vertex each round, lowest index on a tie.
	function automatic void solve_paths(int src, int n);
		bit settled[MaxVertices];
		int pick;
		longint low, nd;
		for (int i = 0; i < n; i++) begin
			path_len[i] = DistInf;
			settled[i] = 0;
		end
		if (src >= n) return;
		path_len[src] = '0;
		for (int r = 0; r < n; r++) begin
			pick = n;
			low = DistInf;
			for (int i = 0; i < n; i++)
				if (!settled[i] && path_len[i] < low) begin
					low = path_len[i];
					pick = i;
				end
			if (pick >= n) break;
			settled[pick] = 1;
			for (int e = 0; e < stored_edges; e++) begin
				if (store_a[e] >= n || store_b[e] >= n) continue;
				nd = longint'(path_len[pick]) + store_w[e];
				if (nd > DistInf) nd = DistInf;
				if (store_a[e] == pick && nd < path_len[store_b[e]])
					path_len[store_b[e]] = DistBits'(nd);
				if (store_b[e] == pick && nd < path_len[store_a[e]])
					path_len[store_a[e]] = DistBits'(nd);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n;
		dist_beat_t want;
		if (!arst_n) begin
			stored_edges = 0;
			drop_seen = 0;
			vcount = 7'd64;
			expected_dists.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			runs_seen = 0;
		end else begin
			if (done) begin
				if (expected_dists.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result beat vertex %0d dist %0d",
							$time, vertex_index, distance);
				end else begin
					want = expected_dists.pop_front();
					checked++;
					if (vertex_index !== want.vidx || distance !== want.path_dist ||
							last_vertex !== want.last || edges_dropped !== want.dropped) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp v%0d d%0d l%0d x%0d got v%0d d%0d l%0d x%0d",
								$time, want.vidx, want.path_dist, want.last, want.dropped,
								vertex_index, distance, last_vertex, edges_dropped);
					end
				end
			end
			if (start && !busy) begin
				n = live_vertices();
				if (opcode == OP_ADD) begin
					if (node_a >= n || node_b >= n || stored_edges >= MaxEdges) begin
						drop_seen = 1;
					end else begin
						store_a[stored_edges] = node_a;
						store_b[stored_edges] = node_b;
						store_w[stored_edges] = edge_weight;
						stored_edges++;
					end
				end else begin
					runs_seen++;
					solve_paths(node_a, n);
					for (int i = 0; i < n; i++) begin
						want.vidx = VertBits'(i);
						want.path_dist = path_len[i];
						want.last = (i == n - 1);
						want.dropped = drop_seen;
						expected_dists.insert(expected_dists.size(), want);
					end
				end
			end
			// the count written at this edge applies from the next beat on
			if (cfg_we)
				vcount = cfg_wdata;
			pending = expected_dists.size();
		end
	end
endmodule

// ----- dv/single_source_shortest_paths_top_tb.sv -----
// Testbench top for the shortest-path block: clock, reset, edge/run command
// stimulus and vertex_count settings; checking is done in sssp_checker.
// Depends on sssp_pkg, single_source_shortest_paths_top and sssp_checker.
`timescale 1ns / 1ps
module single_source_shortest_paths_top_tb;
	import sssp_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_we;
	logic [6:0] cfg_wdata;
	logic opcode;
	logic [5:0] node_a;
	logic [5:0] node_b;
	logic [15:0] edge_weight;
	logic done;
	logic [5:0] vertex_index;
	logic [30:0] distance;
	logic last_vertex;
	logic edges_dropped;
	int errors, pending, checked, runs_seen;
	int gap_pct;
	int live_n;

	single_source_shortest_paths_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .opcode(opcode),
		.node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
		.done(done), .vertex_index(vertex_index), .distance(distance),
		.last_vertex(last_vertex), .edges_dropped(edges_dropped)
	);

	sssp_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .opcode(opcode),
		.node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
		.done(done), .vertex_index(vertex_index), .distance(distance),
		.last_vertex(last_vertex), .edges_dropped(edges_dropped),
		.errors(errors), .pending(pending), .checked(checked), .runs_seen(runs_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Called at a rising edge; returns at the edge that took the beat.
	task automatic issue(input logic op, input int a, input int b, input int w);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		node_a <= 6'(a);
		node_b <= 6'(b);
		edge_weight <= 16'(w);
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
	endtask

	// Drain, then let a trailing add finish, then write the count.
	task automatic set_count(input int value);
		start <= 1'b0;
		forever begin
			@(negedge clk);
			if (pending == 0 && !busy) break;
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		live_n = (value == 0) ? 1 : (value > MaxVertices ? MaxVertices : value);
	endtask

	task automatic random_item();
		int a, b;
		if ($urandom_range(99) < 20) begin
			a = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(live_n - 1);
			issue(OP_RUN, a, $urandom_range(63), $urandom_range(65535));
		end else begin
			a = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(live_n - 1);
			b = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(live_n - 1);
			issue(OP_ADD, a, b,
				($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200));
		end
	endtask

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		opcode = OP_ADD;
		node_a = '0;
		node_b = '0;
		edge_weight = '0;
		gap_pct = 0;
		live_n = MaxVertices;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, self loop, parallel path, reset count of 64
		issue(OP_ADD, 0, 63, 65535);
		issue(OP_ADD, 63, 0, 0);
		issue(OP_ADD, 5, 5, 7);
		issue(OP_ADD, 0, 1, 1);
		issue(OP_ADD, 1, 2, 2);
		issue(OP_ADD, 0, 2, 10);
		issue(OP_RUN, 0, 63, 65535);
		issue(OP_RUN, 63, 0, 0);
		// zero count acts as one vertex; bad edges and bad source
		set_count(0);
		issue(OP_ADD, 0, 0, 3);
		issue(OP_ADD, 1, 0, 1);
		issue(OP_RUN, 0, 0, 0);
		issue(OP_RUN, 63, 0, 0);
		// count above the maximum clamps
		set_count(127);
		issue(OP_RUN, 2, 0, 0);
		// count lowered after loading: edges to vertex 63 skipped
		set_count(3);
		issue(OP_RUN, 0, 0, 0);
		issue(OP_RUN, 5, 0, 0);

		set_count(12);
		gap_pct = 11;
		repeat (24) random_item();
		set_count(6);
		gap_pct = 74;
		repeat (24) random_item();
		set_count(40);
		gap_pct = 0;
		repeat (24) random_item();
		set_count(1);
		issue(OP_RUN, 0, 0, 0);

		// more edges across the full vertex range, then full-size runs
		set_count(64);
		repeat (12) issue(OP_ADD, $urandom_range(63), $urandom_range(63),
			$urandom_range(65535));
		issue(OP_RUN, $urandom_range(63), 0, 0);
		set_count(127);
		issue(OP_RUN, 0, 0, 0);

		start <= 1'b0;
		forever begin
			@(negedge clk);
			if (pending == 0) break;
		end
		repeat (50) @(posedge clk);
		$display("Covered %0d path runs, %0d distance beats checked, counts 1 to 64",
			runs_seen, checked);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d failures", errors);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
